### rtl/wkgp_pkg.sv
package wkgp_pkg;

    localparam int MAX_ITEMS_DEF = 4096;
    localparam int HW            = 16;
    localparam int WW            = 16;
    localparam int KEYW          = HW + WW;
    localparam int CFGW          = 13;
    localparam int DPW           = 48;

    localparam logic CFG_NUM_ITEMS  = 1'b0;
    localparam logic CFG_NUM_GROUPS = 1'b1;

endpackage

### rtl/wkgp_mul.sv
module wkgp_mul #(
    parameter int BW = 28
) (
    input  logic                            aclk,
    input  logic [wkgp_pkg::HW-1:0]         a,
    input  logic [BW-1:0]                   b,
    output logic [wkgp_pkg::HW+BW-1:0]      p_reg
);

    always_ff @(posedge aclk) begin
        p_reg <= (wkgp_pkg::HW+BW)'(a) * (wkgp_pkg::HW+BW)'(b);
    end

endmodule

### rtl/weighted_k_group_partition_dp.sv
// Load: one word per cycle into the item memory; the last word of a job starts the compute.
// Compute: insertion sort of the keys, then a prefix pass over the items, then the layer
// passes on the shared multiplier.
// Layers stop at num_groups or when a layer leaves the table unchanged; s_tready stays low
// from the last word of a job until its result is posted.
// Reset (aresetn low, synchronous) clears control state; result valid drops, loading restarts.
module weighted_k_group_partition_dp #(
    parameter int MAX_ITEMS = wkgp_pkg::MAX_ITEMS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // item_height[15:0], item_weight[31:16]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [47:0]                 m_tdata,   // min_cost[47:0]
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [wkgp_pkg::CFGW-1:0]   cfg_data
);

    localparam int AW  = $clog2(MAX_ITEMS);
    localparam int IW  = $clog2(MAX_ITEMS + 1);
    localparam int WPW = wkgp_pkg::WW + AW;
    localparam int PW  = wkgp_pkg::HW + WPW;
    localparam int DPW = wkgp_pkg::DPW;
    localparam int KW  = wkgp_pkg::KEYW;
    localparam int CW  = wkgp_pkg::CFGW;

    localparam logic [4:0] ST_LOAD   = 5'd0;
    localparam logic [4:0] ST_SI     = 5'd1;
    localparam logic [4:0] ST_SIL    = 5'd2;
    localparam logic [4:0] ST_SJ     = 5'd3;
    localparam logic [4:0] ST_SJC    = 5'd4;
    localparam logic [4:0] ST_PINIT  = 5'd5;
    localparam logic [4:0] ST_PRD    = 5'd6;
    localparam logic [4:0] ST_PMUL   = 5'd7;
    localparam logic [4:0] ST_PMUL2  = 5'd8;
    localparam logic [4:0] ST_PWR    = 5'd9;
    localparam logic [4:0] ST_LSTART = 5'd10;
    localparam logic [4:0] ST_MSTART = 5'd11;
    localparam logic [4:0] ST_MLOAD  = 5'd12;
    localparam logic [4:0] ST_IRD    = 5'd13;
    localparam logic [4:0] ST_IDIFF  = 5'd14;
    localparam logic [4:0] ST_IADD   = 5'd15;
    localparam logic [4:0] ST_MEND   = 5'd16;
    localparam logic [4:0] ST_LEND   = 5'd17;
    localparam logic [4:0] ST_FIN    = 5'd18;

    logic [CW-1:0] num_items_reg, num_groups_reg;

    logic [4:0]     state_reg, state_next;
    logic [IW-1:0]  cnt_reg, cnt_next, n_reg, n_next;
    logic [IW-1:0]  i_reg, i_next, j_reg, j_next, m_reg, m_next;
    logic [KW-1:0]  cur_reg, cur_next;
    logic [WPW-1:0] wacc_reg, wacc_next, wm_reg, wm_next;
    logic [wkgp_pkg::HW-1:0] h0_reg, h0_next;
    logic [DPW-1:0] ws_reg, ws_next, best_reg, best_next, mold_reg, mold_next;
    logic [DPW-1:0] dpi_reg, dpi_next, dpn_reg, dpn_next;
    logic           sel_reg, sel_next, changed_reg, changed_next;
    logic [CW-1:0]  layer_reg, layer_next;
    logic           ovalid_reg, ovalid_next;
    logic [DPW-1:0] odata_reg, odata_next;

    logic [KW-1:0]  kmem [0:MAX_ITEMS-1];
    logic [WPW-1:0] wpmem [0:MAX_ITEMS];
    logic [DPW-1:0] dpmem [0:(2**(IW+1))-1];

    logic           k_we, wp_we, dp_we;
    logic [AW-1:0]  k_wa, k_ra;
    logic [KW-1:0]  k_wd, k_rd;
    logic [IW-1:0]  wp_wa, wp_ra;
    logic [WPW-1:0] wp_wd, wp_rd;
    logic [IW:0]    dp_wa, dp_ra;
    logic [DPW-1:0] dp_wd, dp_rd;

    logic [wkgp_pkg::HW-1:0] mul_a;
    logic [WPW-1:0] mul_b;
    logic [PW-1:0]  prod;
    logic [DPW-1:0] prod_x, cand;
    logic [IW-1:0]  want, cnt_inc, i_inc;
    logic [CW-1:0]  layers;
    logic           s_acc;

    wkgp_mul #(.BW(WPW)) u_mul (
        .aclk  (aclk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (prod)
    );

    always_ff @(posedge aclk) begin
        if (k_we) begin
            kmem[k_wa] <= k_wd;
        end
        k_rd <= kmem[k_ra];
        if (wp_we) begin
            wpmem[wp_wa] <= wp_wd;
        end
        wp_rd <= wpmem[wp_ra];
        if (dp_we) begin
            dpmem[dp_wa] <= dp_wd;
        end
        dp_rd <= dpmem[dp_ra];
    end

    assign prod_x   = DPW'(prod);
    assign cand     = dpi_reg + prod_x;
    assign cnt_inc  = cnt_reg + IW'(1);
    assign i_inc    = i_reg + IW'(1);
    assign layers   = (num_groups_reg == '0) ? CW'(1) : num_groups_reg;
    assign want     = (num_items_reg == '0) ? IW'(1) :
                      ((32'(num_items_reg) > 32'(MAX_ITEMS)) ? IW'(MAX_ITEMS) :
                       IW'(num_items_reg));
    assign s_tready = (state_reg == ST_LOAD);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    // key memory word: height in the upper half, weight in the lower half
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        m_next       = m_reg;
        cur_next     = cur_reg;
        wacc_next    = wacc_reg;
        wm_next      = wm_reg;
        h0_next      = h0_reg;
        ws_next      = ws_reg;
        best_next    = best_reg;
        mold_next    = mold_reg;
        dpi_next     = dpi_reg;
        dpn_next     = dpn_reg;
        sel_next     = sel_reg;
        changed_next = changed_reg;
        layer_next   = layer_reg;
        ovalid_next  = ovalid_reg;
        odata_next   = odata_reg;
        k_we  = 1'b0;
        k_wa  = cnt_reg[AW-1:0];
        k_wd  = {s_tdata[15:0], s_tdata[31:16]};
        k_ra  = i_reg[AW-1:0];
        wp_we = 1'b0;
        wp_wa = '0;
        wp_wd = '0;
        wp_ra = i_reg;
        dp_we = 1'b0;
        dp_wa = {sel_reg, IW'(0)};
        dp_wd = '0;
        dp_ra = {sel_reg, i_reg};
        mul_a = '0;
        mul_b = '0;

        if (ovalid_reg && m_tready) begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD: begin
                if (s_acc) begin
                    k_we = 1'b1;
                    if (cnt_inc >= want) begin
                        n_next     = cnt_inc;
                        cnt_next   = '0;
                        i_next     = IW'(1);
                        state_next = ST_SI;
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
            end
            ST_SI: begin
                if (i_reg >= n_reg) begin
                    state_next = ST_PINIT;
                end else begin
                    state_next = ST_SIL;
                end
            end
            ST_SIL: begin
                cur_next   = k_rd;
                j_next     = i_reg;
                state_next = ST_SJ;
            end
            ST_SJ: begin
                if (j_reg == '0) begin
                    k_we       = 1'b1;
                    k_wa       = '0;
                    k_wd       = cur_reg;
                    i_next     = i_inc;
                    state_next = ST_SI;
                end else begin
                    k_ra       = AW'(j_reg - IW'(1));
                    state_next = ST_SJC;
                end
            end
            ST_SJC: begin
                k_we = 1'b1;
                k_wa = j_reg[AW-1:0];
                if (k_rd > cur_reg) begin
                    k_wd       = k_rd;
                    j_next     = j_reg - IW'(1);
                    state_next = ST_SJ;
                end else begin
                    k_wd       = cur_reg;
                    i_next     = i_inc;
                    state_next = ST_SI;
                end
            end
            ST_PINIT: begin
                wp_we      = 1'b1;
                dp_we      = 1'b1;
                wacc_next  = '0;
                ws_next    = '0;
                i_next     = '0;
                state_next = ST_PRD;
            end
            ST_PRD: begin
                state_next = ST_PMUL;
            end
            ST_PMUL: begin
                mul_a     = k_rd[31:16];
                mul_b     = WPW'(k_rd[15:0]);
                wacc_next = wacc_reg + WPW'(k_rd[15:0]);
                if (i_reg == '0) begin
                    h0_next = k_rd[31:16];
                end
                state_next = ST_PMUL2;
            end
            ST_PMUL2: begin
                ws_next    = ws_reg + prod_x;
                mul_a      = h0_reg;
                mul_b      = wacc_reg;
                state_next = ST_PWR;
            end
            ST_PWR: begin
                wp_we  = 1'b1;
                wp_wa  = i_inc;
                wp_wd  = wacc_reg;
                dp_we  = 1'b1;
                dp_wa  = {sel_reg, i_inc};
                dp_wd  = prod_x;
                i_next = i_inc;
                if (i_inc == n_reg) begin
                    dpn_next   = prod_x;
                    layer_next = CW'(1);
                    state_next = ST_LSTART;
                end else begin
                    state_next = ST_PRD;
                end
            end
            ST_LSTART: begin
                if (layer_reg >= layers) begin
                    state_next = ST_FIN;
                end else begin
                    changed_next = 1'b0;
                    dp_we        = 1'b1;
                    dp_wa        = {~sel_reg, IW'(0)};
                    m_next       = IW'(1);
                    state_next   = ST_MSTART;
                end
            end
            ST_MSTART: begin
                dp_ra      = {sel_reg, m_reg};
                wp_ra      = m_reg;
                state_next = ST_MLOAD;
            end
            ST_MLOAD: begin
                best_next  = dp_rd;
                mold_next  = dp_rd;
                wm_next    = wp_rd;
                i_next     = '0;
                state_next = ST_IRD;
            end
            ST_IRD: begin
                if (i_reg == m_reg) begin
                    state_next = ST_MEND;
                end else begin
                    state_next = ST_IDIFF;
                end
            end
            ST_IDIFF: begin
                mul_a      = k_rd[31:16];
                mul_b      = wm_reg - wp_rd;
                dpi_next   = dp_rd;
                state_next = ST_IADD;
            end
            ST_IADD: begin
                if (cand > best_reg) begin
                    best_next = cand;
                end
                i_next     = i_inc;
                state_next = ST_IRD;
            end
            ST_MEND: begin
                dp_we = 1'b1;
                dp_wa = {~sel_reg, m_reg};
                dp_wd = best_reg;
                if (best_reg != mold_reg) begin
                    changed_next = 1'b1;
                end
                if (m_reg == n_reg) begin
                    dpn_next   = best_reg;
                    state_next = ST_LEND;
                end else begin
                    m_next     = m_reg + IW'(1);
                    state_next = ST_MSTART;
                end
            end
            ST_LEND: begin
                layer_next = layer_reg + CW'(1);
                sel_next   = ~sel_reg;
                if (changed_reg) begin
                    state_next = ST_LSTART;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!ovalid_reg) begin
                    ovalid_next = 1'b1;
                    odata_next  = ws_reg - dpn_reg;
                    state_next  = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_items_reg  <= CW'(1);
            num_groups_reg <= CW'(1);
        end else if (cfg_we) begin
            if (cfg_index == wkgp_pkg::CFG_NUM_ITEMS) begin
                num_items_reg <= cfg_data;
            end else begin
                num_groups_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            cnt_reg    <= '0;
            sel_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            sel_reg    <= sel_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        m_reg       <= m_next;
        cur_reg     <= cur_next;
        wacc_reg    <= wacc_next;
        wm_reg      <= wm_next;
        h0_reg      <= h0_next;
        ws_reg      <= ws_next;
        best_reg    <= best_next;
        mold_reg    <= mold_next;
        dpi_reg     <= dpi_next;
        dpn_reg     <= dpn_next;
        changed_reg <= changed_next;
        layer_reg   <= layer_next;
        odata_reg   <= odata_next;
    end

endmodule

### rtl/wkgp_checker.sv
module wkgp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    a_rst_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_rst_in: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("not ready to load after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result word without compute time");

endmodule

bind weighted_k_group_partition_dp wkgp_checker u_wkgp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
